// ===== rtl/core/tcb_pkg.sv =====
// Shared types, constants and helper functions of the timeout channel bank.
`default_nettype none

package tcb_pkg;

  // Bank size and width of the shared time counter.
  localparam int CHANNELS    = 16;
  localparam int TIME_BITS   = 32;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  localparam time_t TIME_MAX = '1;

  // Operation codes.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_RAISE   = 3'd4;
  localparam logic [2:0] OP_TAKE    = 3'd5;
  localparam logic [2:0] OP_SET     = 3'd6;
  localparam logic [2:0] OP_DEFINE  = 3'd7;

  // Input item as seen on the port.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  channel;
    logic [23:0] length;
    logic        flag;
  } in_item_t;

  // Result item as seen on the port.
  typedef struct packed {
    logic [3:0]  echo_channel;
    logic        is_started;
    logic        is_signaled;
    logic        was_triggered;
    logic [23:0] length_now;
    logic [15:0] fired_mask;
    logic [31:0] time_now;
  } out_item_t;

  // Decoded command held in the queue.
  typedef struct packed {
    logic            is_tick;
    logic            in_range;
    logic [2:0]      op;
    logic [3:0]      channel;
    logic [CH_W-1:0] chan_idx;
    logic [23:0]     length;
    logic            flag;
  } cmd_t;

  // Saturating add onto the time counter.
  function automatic time_t sat_add(input time_t a, input logic [63:0] b);
    logic [64:0] s;
    begin
      s = 65'(a) + 65'(b);
      if (s > 65'(TIME_MAX)) begin
        return TIME_MAX;
      end
      return s[TIME_BITS-1:0];
    end
  endfunction

  // Channel field to an index into the bank.
  function automatic logic [CH_W-1:0] chan_idx(input logic [3:0] ch);
    logic [63:0] w;
    begin
      w = 64'(ch);
      return w[CH_W-1:0];
    end
  endfunction

  // Low sixteen bits of a per-channel vector.
  function automatic logic [15:0] low16(input logic [CHANNELS-1:0] f);
    logic [63:0] w;
    begin
      w = 64'(f);
      return w[15:0];
    end
  endfunction

  // Low thirty-two bits of the time counter.
  function automatic logic [31:0] low32(input time_t t);
    logic [63:0] w;
    begin
      w = 64'(t);
      return w[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/timeout_channel_bank_core.sv =====
// Top level of the timeout channel bank: front end, command queue and back end.
//
// Usage: drive in_item and raise start; the transfer happens at a rising edge
// where start is high and busy is low. The front end decodes the item into a
// two-entry command queue, so busy rises only when that queue is full.
// Each item yields exactly one result, shown on out_item for one cycle while
// out_valid is high; the receiver must take it then, it cannot stall.
// A channel command is executed once it heads the queue and the back end is
// idle; its result is registered. A tick first updates the time counter, then
// checks the channels one per cycle in the scan state; its result is
// registered with the check of the last channel. The back end handles one
// command at a time and pops none while a tick scans, one channel at a time,
// set by the single read port of the per-channel state. tick_step is written
// via cfg_we and cfg_wdata; the user must do so only while idle (not enforced).
// A synchronous reset (rst_n low) empties the queue, sets the time counter to
// zero, stops and clears every channel with length zero, and sets tick_step
// to one.
`default_nettype none

module timeout_channel_bank_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tcb_pkg::in_item_t in_item,
  output logic               busy,
  output logic               out_valid,
  output tcb_pkg::out_item_t out_item,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata
);

  tcb_pkg::cmd_t head;
  logic          head_valid;
  logic          pop;

  tcb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tcb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tcb_front.sv =====
// Front end: accepts items, decodes them and queues the commands.
`default_nettype none

module tcb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tcb_pkg::in_item_t in_item,
  output logic               busy,
  output logic               head_valid,
  output tcb_pkg::cmd_t      head,
  input  wire logic          pop
);

  tcb_pkg::cmd_t                  q_r [tcb_pkg::QUEUE_DEPTH];
  logic [tcb_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [tcb_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [tcb_pkg::QCNT_W-1:0]     count_r;
  logic [tcb_pkg::QCNT_W-1:0]     count_nxt;
  tcb_pkg::cmd_t                  dec;
  logic                           push;

  // Classify the incoming item.
  always_comb begin
    dec.is_tick  = (in_item.opcode == tcb_pkg::OP_TICK);
    dec.in_range = (32'(in_item.channel) < 32'(tcb_pkg::CHANNELS));
    dec.op       = in_item.opcode;
    dec.channel  = in_item.channel;
    dec.chan_idx = tcb_pkg::chan_idx(in_item.channel);
    dec.length   = in_item.length;
    dec.flag     = in_item.flag;
  end

  assign busy       = (count_r == tcb_pkg::QCNT_W'(tcb_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Queue storage; each transfer writes at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == tcb_pkg::QPTR_W'(tcb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == tcb_pkg::QPTR_W'(tcb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcb_back.sv =====
// Back end: executes queued commands on the channel bank and the time counter.
`default_nettype none

module tcb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire tcb_pkg::cmd_t head,
  output logic               pop,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  output logic               out_valid,
  output tcb_pkg::out_item_t out_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                            state_r;
  logic [15:0]                     tick_step_r;
  tcb_pkg::time_t                  time_r;
  logic [23:0]                     len_r [tcb_pkg::CHANNELS];
  tcb_pkg::time_t                  dl_r  [tcb_pkg::CHANNELS];
  logic [tcb_pkg::CHANNELS-1:0]    started_r;
  logic [tcb_pkg::CHANNELS-1:0]    sig_r;
  logic [tcb_pkg::CH_W-1:0]        idx_r;
  logic [tcb_pkg::CHANNELS-1:0]    fired_r;
  logic                            out_valid_r;
  tcb_pkg::out_item_t              out_item_r;

  logic                            state_nxt;
  tcb_pkg::time_t                  time_nxt;
  logic [tcb_pkg::CH_W-1:0]        idx_nxt;
  logic [tcb_pkg::CHANNELS-1:0]    fired_nxt;
  logic                            out_valid_nxt;
  tcb_pkg::out_item_t              out_item_nxt;

  logic [tcb_pkg::CH_W-1:0]        rd_idx;
  logic [23:0]                     len_c;
  tcb_pkg::time_t                  dl_c;
  logic                            st_c;
  logic                            sg_c;
  logic                            we;
  logic [23:0]                     wl;
  tcb_pkg::time_t                  wd;
  logic                            ws;
  logic                            wg;
  logic                            trig;
  logic                            fire;
  logic                            expire;
  logic [23:0]                     new_len;
  logic [tcb_pkg::CHANNELS-1:0]    fired_or;
  logic                            scan_last;
  tcb_pkg::out_item_t              op_res;

  assign pop       = (state_r == ST_IDLE) && head_valid;
  assign rd_idx    = (state_r == ST_SCAN) ? idx_r : head.chan_idx;
  assign len_c     = len_r[rd_idx];
  assign dl_c      = dl_r[rd_idx];
  assign st_c      = started_r[rd_idx];
  assign sg_c      = sig_r[rd_idx];
  assign new_len   = (head.length != 24'd0) ? head.length : len_c;
  assign scan_last = (idx_r == tcb_pkg::CH_W'(tcb_pkg::CHANNELS - 1));
  assign expire    = (state_r == ST_SCAN) && st_c && !sg_c && (dl_c <= time_r);
  assign fired_or  = fired_r | ({{(tcb_pkg::CHANNELS-1){1'b0}}, expire} << idx_r);

  // Next value of the one channel entry touched this cycle.
  always_comb begin
    we   = 1'b0;
    wl   = len_c;
    wd   = dl_c;
    ws   = st_c;
    wg   = sg_c;
    trig = 1'b0;
    fire = 1'b0;
    if (state_r == ST_SCAN) begin
      we = expire;
      ws = 1'b0;
      wg = 1'b1;
    end else if (pop && !head.is_tick && head.in_range) begin
      we = 1'b1;
      case (head.op)
        tcb_pkg::OP_START: begin
          if (!st_c) begin
            wd = tcb_pkg::sat_add(time_r, 64'(len_c));
            wg = 1'b0;
            ws = 1'b1;
          end
        end
        tcb_pkg::OP_RESTART: begin
          wl = new_len;
          wd = tcb_pkg::sat_add(time_r, 64'(new_len));
          wg = 1'b0;
          ws = 1'b1;
        end
        tcb_pkg::OP_STOP: begin
          if (st_c) begin
            wd = '0;
            wg = 1'b0;
            ws = 1'b0;
          end
        end
        tcb_pkg::OP_RAISE: begin
          if (len_c < head.length) begin
            wl = head.length;
          end
        end
        tcb_pkg::OP_TAKE: begin
          trig = sg_c;
          wg   = 1'b0;
        end
        tcb_pkg::OP_SET: begin
          wg = head.flag;
          if (head.flag && st_c) begin
            ws   = 1'b0;
            fire = 1'b1;
          end
        end
        tcb_pkg::OP_DEFINE: begin
          wl = head.length;
          wg = head.flag;
          ws = 1'b0;
          wd = '0;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // Result of a single-channel command.
  always_comb begin
    op_res              = '0;
    op_res.echo_channel = head.channel;
    op_res.time_now     = tcb_pkg::low32(time_r);
    if (head.in_range) begin
      op_res.is_started    = ws;
      op_res.is_signaled   = wg;
      op_res.was_triggered = trig;
      op_res.length_now    = wl;
      op_res.fired_mask    = tcb_pkg::low16(
        {{(tcb_pkg::CHANNELS-1){1'b0}}, fire} << head.chan_idx);
    end
  end

  // Tick scan sequencer, time counter and result register next values.
  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    idx_nxt       = idx_r;
    fired_nxt     = fired_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (head.is_tick) begin
            time_nxt  = tcb_pkg::sat_add(time_r, 64'(tick_step_r));
            idx_nxt   = '0;
            fired_nxt = '0;
            state_nxt = ST_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = op_res;
          end
        end
      end
      ST_SCAN: begin
        fired_nxt = fired_or;
        idx_nxt   = idx_r + 1'b1;
        if (scan_last) begin
          state_nxt               = ST_IDLE;
          out_valid_nxt           = 1'b1;
          out_item_nxt            = '0;
          out_item_nxt.fired_mask = tcb_pkg::low16(fired_or);
          out_item_nxt.time_now   = tcb_pkg::low32(time_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Channel bank, time counter, tick scan sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_step_r <= 16'd1;
      time_r      <= '0;
      started_r   <= '0;
      sig_r       <= '0;
      idx_r       <= '0;
      fired_r     <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
      for (int i = 0; i < tcb_pkg::CHANNELS; i++) begin
        len_r[i] <= '0;
        dl_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      idx_r       <= idx_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
      if (cfg_we) begin
        tick_step_r <= cfg_wdata;
      end
      if (we) begin
        len_r[rd_idx]     <= wl;
        dl_r[rd_idx]      <= wd;
        started_r[rd_idx] <= ws;
        sig_r[rd_idx]     <= wg;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcb_checker.sv =====
// Port-level checker for the timeout channel bank and its bind statement.
`default_nettype none

module tcb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire tcb_pkg::out_item_t out_item
);

  // Reset leaves no result pending and the queue open.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result or busy seen right after reset");

  // Taking the signal always leaves it cleared.
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.was_triggered |-> !out_item.is_signaled)
    else $error("take signal left the signal set");

  // Taking the signal never fires a channel.
  a_take_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.was_triggered |-> out_item.fired_mask == 16'd0)
    else $error("take signal fired a channel");

  // A channel still running after the item cannot have fired on it.
  a_run_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_started |-> out_item.fired_mask == 16'd0)
    else $error("running channel reported a fire");

endmodule

bind timeout_channel_bank_core tcb_checker u_tcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
